// ----- rtl/fsspe_pkg.sv -----
// Package for the flash sector store: geometry constants, operation codes,
// controller states and the memory request bundle. No dependencies.
package fsspe_pkg;

  // Store geometry. Both counts are powers of two, so block and sector
  // indexes are bit fields of the sector number.
  localparam int unsigned NUM_BLOCKS        = 512;
  localparam int unsigned SECTORS_PER_BLOCK = 32;

  // Fixed field widths.
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned PSN_W  = 14;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned EBLK_W = 9;
  localparam int unsigned CNT_W  = 32;

  // Derived widths.
  localparam int unsigned SEC_W = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
  localparam int unsigned BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned ROW_W = SECTORS_PER_BLOCK * BYTE_W;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_ERASE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_e;

  // One access to the row memory: one write port, one registered read port.
  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/flash_sector_store_program_erase.sv -----
// Top level of the flash sector store with erase-before-write rules.
// Depends on fsspe_pkg, fsspe_mem and fsspe_ctrl.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   request  | start_i / busy_o          | func_i, sector_number_i, write_byte_i,
//            |                           | erase_block_i
//   result   | result_valid_o (1 cycle)  | read_byte_o, status_o, writes_done_o,
//            |                           | erases_done_o, write_attempts_o
//
// A read or a write reads the block row from the row memory, then modifies it
// and writes it back; the next transaction is taken after that.
// An erase or an unused operation needs no modify step, since a block is one memory row.
// The result appears the cycle after the transaction completes, for one cycle.
// After reset a clearing pass zeroes the store, one row per cycle, with busy_o high
// until all NUM_BLOCKS (512) rows are cleared. The receiver cannot stall the result.
module flash_sector_store_program_erase (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [fsspe_pkg::FUNC_W-1:0] func_i,
  input  logic [fsspe_pkg::PSN_W-1:0]  sector_number_i,
  input  logic [fsspe_pkg::BYTE_W-1:0] write_byte_i,
  input  logic [fsspe_pkg::EBLK_W-1:0] erase_block_i,
  output logic                         result_valid_o,
  output logic [fsspe_pkg::BYTE_W-1:0] read_byte_o,
  output logic                         status_o,
  output logic [fsspe_pkg::CNT_W-1:0]  writes_done_o,
  output logic [fsspe_pkg::CNT_W-1:0]  erases_done_o,
  output logic [fsspe_pkg::CNT_W-1:0]  write_attempts_o
);

  fsspe_pkg::mem_req_t         mem_req;
  logic [fsspe_pkg::ROW_W-1:0] mem_rdata;

  // Sequencer, counters and result registers.
  fsspe_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .sector_number_i  (sector_number_i),
    .write_byte_i     (write_byte_i),
    .erase_block_i    (erase_block_i),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .result_valid_o   (result_valid_o),
    .read_byte_o      (read_byte_o),
    .status_o         (status_o),
    .writes_done_o    (writes_done_o),
    .erases_done_o    (erases_done_o),
    .write_attempts_o (write_attempts_o)
  );

  // Sector store, one row per block.
  fsspe_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // An accepted erase yields a result next cycle with the erase count advanced.
  a_erase_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (func_i == fsspe_pkg::FUNC_ERASE) |=>
      result_valid_o && (erases_done_o == $past(erases_done_o) + 32'd1))
    else $error("erase transaction did not produce its result");

  // A refused write counts as an attempt but not as a successful write.
  a_refused_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |->
      (write_attempts_o == $past(write_attempts_o) + 32'd1) &&
      (writes_done_o == $past(writes_done_o)))
    else $error("refused write updated the counters wrongly");

  // A successful write is always also a write attempt.
  a_write_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (writes_done_o != $past(writes_done_o)) |->
      (write_attempts_o != $past(write_attempts_o)))
    else $error("write count moved without a write attempt");

endmodule

// ----- rtl/fsspe_mem.sv -----
// Row memory of the flash sector store: one row per block, one byte per sector.
// Depends on fsspe_pkg for widths and the request bundle.
module fsspe_mem (
  input  logic                        clk_i,
  input  fsspe_pkg::mem_req_t         req_i,
  output logic [fsspe_pkg::ROW_W-1:0] rdata_o
);

  logic [fsspe_pkg::ROW_W-1:0] mem_q [fsspe_pkg::NUM_BLOCKS];
  logic [fsspe_pkg::ROW_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fsspe_ctrl.sv -----
// Controller of the flash sector store: clearing pass, read-modify-write of a
// block row, block erase, the three transaction counters and the result registers.
// Depends on fsspe_pkg.
module fsspe_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [fsspe_pkg::FUNC_W-1:0] func_i,
  input  logic [fsspe_pkg::PSN_W-1:0]  sector_number_i,
  input  logic [fsspe_pkg::BYTE_W-1:0] write_byte_i,
  input  logic [fsspe_pkg::EBLK_W-1:0] erase_block_i,
  output fsspe_pkg::mem_req_t          mem_req_o,
  input  logic [fsspe_pkg::ROW_W-1:0]  mem_rdata_i,
  output logic                         result_valid_o,
  output logic [fsspe_pkg::BYTE_W-1:0] read_byte_o,
  output logic                         status_o,
  output logic [fsspe_pkg::CNT_W-1:0]  writes_done_o,
  output logic [fsspe_pkg::CNT_W-1:0]  erases_done_o,
  output logic [fsspe_pkg::CNT_W-1:0]  write_attempts_o
);

  fsspe_pkg::state_e state_q, state_d;

  logic [fsspe_pkg::BLK_W-1:0]  clr_q, clr_d;
  fsspe_pkg::func_e             func_q;
  logic [fsspe_pkg::BLK_W-1:0]  blk_q;
  logic [fsspe_pkg::SEC_W-1:0]  sec_q;
  logic [fsspe_pkg::BYTE_W-1:0] data_q;

  logic                         valid_q, valid_d;
  logic [fsspe_pkg::BYTE_W-1:0] rbyte_q, rbyte_d;
  logic                         status_q, status_d;
  logic [fsspe_pkg::CNT_W-1:0]  writes_q, writes_d;
  logic [fsspe_pkg::CNT_W-1:0]  erases_q, erases_d;
  logic [fsspe_pkg::CNT_W-1:0]  attempts_q, attempts_d;

  logic                         accept;
  fsspe_pkg::func_e             func_in;
  logic [fsspe_pkg::BLK_W-1:0]  psn_blk;
  logic [fsspe_pkg::BLK_W-1:0]  erase_blk;
  logic [fsspe_pkg::BYTE_W-1:0] cur_byte;
  logic                         cur_empty;
  logic [fsspe_pkg::ROW_W-1:0]  new_row;

  // Decode of the incoming transaction; out-of-range indexes wrap.
  assign accept    = start_i && (state_q == fsspe_pkg::ST_IDLE);
  assign func_in   = fsspe_pkg::func_e'(func_i);
  assign psn_blk   = fsspe_pkg::BLK_W'(sector_number_i >> fsspe_pkg::SEC_W);
  assign erase_blk = fsspe_pkg::BLK_W'(erase_block_i);

  // Addressed byte of the row just read, and the row with the new byte merged.
  assign cur_byte  = mem_rdata_i[sec_q*fsspe_pkg::BYTE_W +: fsspe_pkg::BYTE_W];
  assign cur_empty = (cur_byte == '0);

  always_comb begin
    new_row = mem_rdata_i;
    new_row[sec_q*fsspe_pkg::BYTE_W +: fsspe_pkg::BYTE_W] = data_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsspe_pkg::ST_CLEAR: begin
        if (clr_q == fsspe_pkg::BLK_W'(fsspe_pkg::NUM_BLOCKS - 1)) begin
          state_d = fsspe_pkg::ST_IDLE;
        end
      end
      fsspe_pkg::ST_IDLE: begin
        if (accept && (func_in == fsspe_pkg::FUNC_READ || func_in == fsspe_pkg::FUNC_WRITE)) begin
          state_d = fsspe_pkg::ST_MODIFY;
        end
      end
      fsspe_pkg::ST_MODIFY: begin
        state_d = fsspe_pkg::ST_IDLE;
      end
      default: begin
        state_d = fsspe_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs: memory accesses, result values and counter updates.
  always_comb begin
    mem_req_o  = '0;
    clr_d      = clr_q;
    valid_d    = 1'b0;
    rbyte_d    = rbyte_q;
    status_d   = status_q;
    writes_d   = writes_q;
    erases_d   = erases_q;
    attempts_d = attempts_q;
    unique case (state_q)
      fsspe_pkg::ST_CLEAR: begin
        // Zero one row per cycle after reset.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_q;
        clr_d           = clr_q + 1'b1;
      end
      fsspe_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func_in)
            fsspe_pkg::FUNC_READ, fsspe_pkg::FUNC_WRITE: begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = psn_blk;
            end
            fsspe_pkg::FUNC_ERASE: begin
              // A whole block is one row, erased in a single write.
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = erase_blk;
              erases_d        = erases_q + 1'b1;
              valid_d         = 1'b1;
              rbyte_d         = '0;
              status_d        = 1'b0;
            end
            fsspe_pkg::FUNC_NOP: begin
              valid_d  = 1'b1;
              rbyte_d  = '0;
              status_d = 1'b0;
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      fsspe_pkg::ST_MODIFY: begin
        valid_d  = 1'b1;
        rbyte_d  = (func_q == fsspe_pkg::FUNC_READ) ? cur_byte : '0;
        status_d = (func_q == fsspe_pkg::FUNC_WRITE) && !cur_empty;
        if (func_q == fsspe_pkg::FUNC_WRITE) begin
          attempts_d = attempts_q + 1'b1;
          if (cur_empty) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = blk_q;
            mem_req_o.wdata = new_row;
            writes_d        = writes_q + 1'b1;
          end
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= fsspe_pkg::ST_CLEAR;
      clr_q      <= '0;
      valid_q    <= 1'b0;
      rbyte_q    <= '0;
      status_q   <= 1'b0;
      writes_q   <= '0;
      erases_q   <= '0;
      attempts_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      valid_q    <= valid_d;
      rbyte_q    <= rbyte_d;
      status_q   <= status_d;
      writes_q   <= writes_d;
      erases_q   <= erases_d;
      attempts_q <= attempts_d;
    end
  end

  // Transaction fields held for the modify cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_in;
      blk_q  <= psn_blk;
      sec_q  <= fsspe_pkg::SEC_W'(sector_number_i);
      data_q <= write_byte_i;
    end
  end

  assign busy_o           = (state_q != fsspe_pkg::ST_IDLE);
  assign result_valid_o   = valid_q;
  assign read_byte_o      = rbyte_q;
  assign status_o         = status_q;
  assign writes_done_o    = writes_q;
  assign erases_done_o    = erases_q;
  assign write_attempts_o = attempts_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the flash sector store with erase-before-write rules.
// Depends on fsspe_pkg and the flash_sector_store_program_erase RTL; a scoreboard
// class predicts every result and plain tasks drive the command interface.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_SECTORS = fsspe_pkg::NUM_BLOCKS * fsspe_pkg::SECTORS_PER_BLOCK;
  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned HOT_BLOCKS    = 4;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_LIMIT  = 10;

  // One result transaction as seen on the result ports.
  typedef struct packed {
    logic [fsspe_pkg::BYTE_W-1:0] read_byte;
    logic                         status;
    logic [fsspe_pkg::CNT_W-1:0]  writes_done;
    logic [fsspe_pkg::CNT_W-1:0]  erases_done;
    logic [fsspe_pkg::CNT_W-1:0]  write_attempts;
  } store_result_t;

  // Scoreboard: keeps its own copy of the sector store and the counters,
  // predicts each result on acceptance and compares results in order.
  class sector_scoreboard;
    logic [fsspe_pkg::BYTE_W-1:0] sector_bytes [TOTAL_SECTORS];
    logic [fsspe_pkg::CNT_W-1:0]  write_total;
    logic [fsspe_pkg::CNT_W-1:0]  erase_total;
    logic [fsspe_pkg::CNT_W-1:0]  attempt_total;
    store_result_t                pending_results [$];
    int unsigned                  error_count;

    function new();
      foreach (sector_bytes[i]) sector_bytes[i] = '0;
      write_total   = '0;
      erase_total   = '0;
      attempt_total = '0;
      error_count   = 0;
    endfunction

    // Applies one accepted command to the predicted store.
    function void note_command(fsspe_pkg::func_e op, logic [fsspe_pkg::PSN_W-1:0] psn,
                               logic [fsspe_pkg::BYTE_W-1:0] data,
                               logic [fsspe_pkg::EBLK_W-1:0] eblk);
      store_result_t               res;
      logic [fsspe_pkg::BLK_W-1:0] blk;
      logic [fsspe_pkg::SEC_W-1:0] sec;
      int unsigned                 idx;
      int unsigned                 base;
      int unsigned                 i;
      res  = '0;
      blk  = fsspe_pkg::BLK_W'(psn / fsspe_pkg::SECTORS_PER_BLOCK);
      sec  = fsspe_pkg::SEC_W'(psn % fsspe_pkg::SECTORS_PER_BLOCK);
      idx  = blk * fsspe_pkg::SECTORS_PER_BLOCK + sec;
      base = (eblk % fsspe_pkg::NUM_BLOCKS) * fsspe_pkg::SECTORS_PER_BLOCK;
      case (op)
        fsspe_pkg::FUNC_READ: begin
          res.read_byte = sector_bytes[idx];
        end
        fsspe_pkg::FUNC_WRITE: begin
          // A sector only takes a program while it still reads as empty.
          if (sector_bytes[idx] == '0) begin
            sector_bytes[idx] = data;
            write_total       = write_total + 1'b1;
          end else begin
            res.status = 1'b1;
          end
          attempt_total = attempt_total + 1'b1;
        end
        fsspe_pkg::FUNC_ERASE: begin
          for (i = 0; i < fsspe_pkg::SECTORS_PER_BLOCK; i++) sector_bytes[base + i] = '0;
          erase_total = erase_total + 1'b1;
        end
        default: begin
        end
      endcase
      res.writes_done    = write_total;
      res.erases_done    = erase_total;
      res.write_attempts = attempt_total;
      pending_results.push_back(res);
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void check_result(store_result_t got);
      store_result_t exp;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: result with no transaction pending: byte=%0h status=%0d", $realtime,
                   got.read_byte, got.status);
        return;
      end
      exp = pending_results.pop_front();
      if (got.read_byte !== exp.read_byte || got.status !== exp.status ||
          got.writes_done !== exp.writes_done || got.erases_done !== exp.erases_done ||
          got.write_attempts !== exp.write_attempts) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: mismatch exp byte=%0h st=%0d wr=%0d er=%0d att=%0d", $realtime,
                   exp.read_byte, exp.status, exp.writes_done, exp.erases_done,
                   exp.write_attempts);
          $display("%0t:          got byte=%0h st=%0d wr=%0d er=%0d att=%0d", $realtime,
                   got.read_byte, got.status, got.writes_done, got.erases_done,
                   got.write_attempts);
        end
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic [fsspe_pkg::FUNC_W-1:0]  func_i = '0;
  logic [fsspe_pkg::PSN_W-1:0]   sector_number_i = '0;
  logic [fsspe_pkg::BYTE_W-1:0]  write_byte_i = '0;
  logic [fsspe_pkg::EBLK_W-1:0]  erase_block_i = '0;
  logic                          result_valid_o;
  logic [fsspe_pkg::BYTE_W-1:0]  read_byte_o;
  logic                          status_o;
  logic [fsspe_pkg::CNT_W-1:0]   writes_done_o;
  logic [fsspe_pkg::CNT_W-1:0]   erases_done_o;
  logic [fsspe_pkg::CNT_W-1:0]   write_attempts_o;

  sector_scoreboard              sb = new();
  logic [fsspe_pkg::BLK_W-1:0]   hot_blocks [HOT_BLOCKS];
  bit                            no_idle = 1'b0;
  int unsigned                   cycle_count = 0;

  flash_sector_store_program_erase u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .sector_number_i  (sector_number_i),
    .write_byte_i     (write_byte_i),
    .erase_block_i    (erase_block_i),
    .result_valid_o   (result_valid_o),
    .read_byte_o      (read_byte_o),
    .status_o         (status_o),
    .writes_done_o    (writes_done_o),
    .erases_done_o    (erases_done_o),
    .write_attempts_o (write_attempts_o)
  );

  always #1 clk_i = ~clk_i;

  // Global watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result monitor: every strobed cycle carries one result transaction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result('{read_byte: read_byte_o, status: status_o,
                        writes_done: writes_done_o, erases_done: erases_done_o,
                        write_attempts: write_attempts_o});
  end

  // Mostly a few hot blocks, so that writes collide and erases matter.
  function automatic logic [fsspe_pkg::BLK_W-1:0] pick_block();
    if ($urandom_range(0, 99) < 75) return hot_blocks[$urandom_range(0, HOT_BLOCKS - 1)];
    return fsspe_pkg::BLK_W'($urandom);
  endfunction

  // Drives one command transaction and waits until the block takes it.
  // Called at a rising edge; start_i stays high between back-to-back commands.
  task automatic send_command(fsspe_pkg::func_e op, logic [fsspe_pkg::PSN_W-1:0] psn,
                              logic [fsspe_pkg::BYTE_W-1:0] data,
                              logic [fsspe_pkg::EBLK_W-1:0] eblk);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    func_i          <= op;
    sector_number_i <= psn;
    write_byte_i    <= data;
    erase_block_i   <= eblk;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(op, psn, data, eblk);
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned                  k;
    int unsigned                  pick;
    fsspe_pkg::func_e             op;
    logic [fsspe_pkg::BYTE_W-1:0] data;

    foreach (hot_blocks[h]) hot_blocks[h] = fsspe_pkg::BLK_W'($urandom);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every operation and the special cases.
    send_command(fsspe_pkg::FUNC_READ,  14'd0,     8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'h3fff,  8'hff, 9'h1ff);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd0,     8'h01, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'h3fff,  8'hff, 9'h1ff);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd0,     8'h80, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'd0,     8'h00, 9'h1ff);
    send_command(fsspe_pkg::FUNC_READ,  14'h3fff,  8'h00, 9'd0);
    // Programming a zero byte leaves the sector empty, so it can be programmed again.
    send_command(fsspe_pkg::FUNC_WRITE, 14'd5,     8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd5,     8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd5,     8'h5a, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd31,    8'ha5, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd32,    8'h3c, 9'd0);
    send_command(fsspe_pkg::FUNC_ERASE, 14'h3fff,  8'hff, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'd0,     8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'd31,    8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'd32,    8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_ERASE, 14'd0,     8'h00, 9'h1ff);
    send_command(fsspe_pkg::FUNC_READ,  14'h3fff,  8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'h3fff,  8'h77, 9'd0);
    // The unused operation reports the counters unchanged.
    send_command(fsspe_pkg::FUNC_NOP,   14'h3fff,  8'hff, 9'h1ff);
    send_command(fsspe_pkg::FUNC_NOP,   14'd0,     8'h00, 9'd0);
    send_command(fsspe_pkg::FUNC_WRITE, 14'd32,    8'h11, 9'd0);
    send_command(fsspe_pkg::FUNC_READ,  14'h3fff,  8'h00, 9'h1ff);
    drain_results();

    // Random part: a mix biased toward hot blocks, with idle-free stretches.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = ((k / 128) % 4) == 2;
      if (k == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = fsspe_pkg::FUNC_READ;
      else if (pick < 88) op = fsspe_pkg::FUNC_WRITE;
      else if (pick < 96) op = fsspe_pkg::FUNC_ERASE;
      else                op = fsspe_pkg::FUNC_NOP;
      data = ($urandom_range(0, 9) == 0) ? 8'h00 : fsspe_pkg::BYTE_W'($urandom);
      send_command(op, {pick_block(), fsspe_pkg::SEC_W'($urandom)}, data,
                   fsspe_pkg::EBLK_W'(pick_block()));
    end
    start_i <= 1'b0;

    // Wait for every outstanding result, then a few more cycles for strays.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0)
      $display("%0d predicted results never arrived", sb.pending_results.size());
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
